FILE: sv/adsr_pkg.sv
// Package for the envelope gain unit: item types, codes, constants and the
// output saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    // Widths of the fixed fields
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int FRAMES_W   = 24;
    localparam int POS_W      = 27;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = 42;
    localparam int DIV_STEPS  = 16;

    typedef logic [1:0] func_t;
    typedef logic [2:0] cfg_idx_t;
    typedef logic [2:0] seg_t;

    // Item codes
    localparam func_t FUNC_AUDIO   = 2'd0;
    localparam func_t FUNC_RELEASE = 2'd1;
    localparam func_t FUNC_RESTART = 2'd2;

    // Register indexes
    localparam cfg_idx_t REG_ATTACK  = 3'd0;
    localparam cfg_idx_t REG_HOLD    = 3'd1;
    localparam cfg_idx_t REG_DECAY   = 3'd2;
    localparam cfg_idx_t REG_SUSTAIN = 3'd3;
    localparam cfg_idx_t REG_RELEASE = 3'd4;

    // Segment numbers
    localparam seg_t SEG_ATTACK  = 3'd0;
    localparam seg_t SEG_HOLD    = 3'd1;
    localparam seg_t SEG_DECAY   = 3'd2;
    localparam seg_t SEG_RELEASE = 3'd3;
    localparam seg_t SEG_END     = 3'd4;

    localparam logic [GAIN_W-1:0] UNITY = 16'h8000;

    typedef struct packed {
        func_t                       func;
        logic signed [SAMPLE_W-1:0]  sample_left;
        logic signed [SAMPLE_W-1:0]  sample_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  out_left;
        logic signed [SAMPLE_W-1:0]  out_right;
        logic        [GAIN_W-1:0]    gain;
        logic                        finished;
    } out_item_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Sequencer states
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_PREP   = 10'b0000000010,
        ST_SCAN   = 10'b0000000100,
        ST_MULOFF = 10'b0000001000,
        ST_DIVGO  = 10'b0000010000,
        ST_DIV    = 10'b0000100000,
        ST_MULL   = 10'b0001000000,
        ST_MULR   = 10'b0010000000,
        ST_SATR   = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } state_t;

    // Floor shift by 15 and clamp to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-16:0] q;
        logic signed [SAMPLE_W-1:0] r;
        q = (PROD_W-15)'(p >>> 15);
        if (q > (PROD_W-15)'(32767))
            r = 16'sh7FFF;
        else if (q < -(PROD_W-15)'(32768))
            r = 16'sh8000;
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/adsr_if.sv
// Valid/ready channels carrying input and result items.
// Depends on adsr_pkg for the item types.
`timescale 1ns / 1ps
`default_nettype none

interface adsr_in_if;
    import adsr_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface adsr_out_if;
    import adsr_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: sv/adsr_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// The quotient is known to fit in DIV_STEPS bits. Depends on adsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adsr_div (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          start,
    input  wire logic [adsr_pkg::FRAMES_W+adsr_pkg::DIV_STEPS-1:0] dividend,
    input  wire logic [adsr_pkg::FRAMES_W-1:0]                 divisor,
    output adsr_pkg::div_stat_t                                stat,
    output logic [adsr_pkg::DIV_STEPS-1:0]                     quotient
);
    import adsr_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [FRAMES_W-1:0]  rem_reg, rem_next;
    logic [DIV_STEPS-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [FRAMES_W:0]    trial;
    logic                 fits;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, sh_reg[DIV_STEPS-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[FRAMES_W+DIV_STEPS-1:DIV_STEPS];
            sh_next   = dividend[DIV_STEPS-1:0];
            cnt_next  = CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? FRAMES_W'(trial - {1'b0, divisor}) : trial[FRAMES_W-1:0];
            sh_next  = {sh_reg[DIV_STEPS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold the working remainder and quotient
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = sh_reg;

endmodule

`default_nettype wire

FILE: sv/adsr_envelope_gain_unit.sv
// Top level of the AHDSR envelope gain unit: register port, sequencer,
// shared multiplier and divider. Depends on adsr_pkg, adsr_if, adsr_div.
`timescale 1ns / 1ps
`default_nettype none

//  Channel     Kind            Payload
//  sample_ch   valid/ready in  func, sample_left, sample_right
//  result_ch   valid/ready out out_left, out_right, gain, finished
//  cfg_*       write only      cfg_idx selects register, cfg_wdata data
//
// Ramp frames go from the accept state through the breakpoint rebuild, the scan
// past any skipped segments, the offset multiply, the divider start, the divider
// and both products to the result load. Sustain frames skip the offset multiply
// and divider. Frames past the end and release and restart items skip all math.
// Reset clears the envelope to its start with the sustain hold armed. Input is
// taken only while idle; a waiting result stalls the sequencer until result_ch.ready.

module adsr_envelope_gain_unit #(
    parameter int CHANNELS = 2
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire adsr_pkg::cfg_idx_t                    cfg_idx,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    adsr_in_if.sink                                    sample_ch,
    adsr_out_if.source                                 result_ch
);
    import adsr_pkg::*;

    // Configuration registers
    logic [FRAMES_W-1:0] attack_reg, hold_reg, decay_reg, release_reg;
    logic [GAIN_W-1:0]   sustain_reg;

    // Envelope state
    state_t            state_reg, state_next;
    seg_t              seg_reg, seg_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              armed_reg, armed_next;
    logic [1:0]        idx_reg, idx_next;

    // Working values
    logic [POS_W-1:0]            x0_reg, x0_next, x1_reg, x1_next;
    logic [FRAMES_W-1:0]         off_reg, off_next, len_reg, len_next;
    logic [GAIN_W-1:0]           y0_reg, y0_next, dy_reg, dy_next;
    logic                        down_reg, down_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [GAIN_W-1:0]           gain_reg, gain_next;
    logic signed [SAMPLE_W-1:0]  sl_reg, sl_next, sr_reg, sr_next;
    logic signed [SAMPLE_W-1:0]  outl_reg, outl_next, outr_reg, outr_next;
    logic                        fin_reg, fin_next;

    // Output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    // Shared multiplier
    logic signed [FRAMES_W:0]   mul_a;
    logic signed [GAIN_W:0]     mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    // Divider
    logic                  div_start;
    div_stat_t             div_stat;
    logic [DIV_STEPS-1:0]  div_q;

    logic [GAIN_W-1:0]   sus;
    logic [POS_W-1:0]    pos_inc;
    logic [FRAMES_W-1:0] prep_len, next_len;
    logic [GAIN_W-1:0]   seg_y0, seg_dy;
    logic                seg_down;

    // Segment length by segment number
    function automatic logic [FRAMES_W-1:0] seg_len(
        input logic [1:0] s,
        input logic [FRAMES_W-1:0] a,
        input logic [FRAMES_W-1:0] h,
        input logic [FRAMES_W-1:0] d,
        input logic [FRAMES_W-1:0] r
    );
        logic [FRAMES_W-1:0] v;
        unique case (s)
            2'd0:    v = a;
            2'd1:    v = h;
            2'd2:    v = d;
            default: v = r;
        endcase
        return v;
    endfunction

    assign sus      = (sustain_reg > UNITY) ? UNITY : sustain_reg;
    assign pos_inc  = pos_reg + POS_W'(1);
    assign prep_len = seg_len(idx_reg, attack_reg, hold_reg, decay_reg, release_reg);
    assign next_len = seg_len(seg_reg[1:0] + 2'd1, attack_reg, hold_reg, decay_reg,
                              release_reg);

    // Start level, level change and direction of the current segment
    always_comb
    begin
        seg_y0   = '0;
        seg_dy   = '0;
        seg_down = 1'b0;
        unique case (seg_reg)
            SEG_ATTACK:
            begin
                seg_y0 = '0;
                seg_dy = UNITY;
            end
            SEG_HOLD:
            begin
                seg_y0 = UNITY;
                seg_dy = '0;
            end
            SEG_DECAY:
            begin
                seg_y0   = UNITY;
                seg_dy   = UNITY - sus;
                seg_down = 1'b1;
            end
            SEG_RELEASE:
            begin
                seg_y0   = sus;
                seg_dy   = sus;
                seg_down = 1'b1;
            end
            default:
            begin
                seg_y0 = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        pos_next       = pos_reg;
        armed_next     = armed_reg;
        idx_next       = idx_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        y0_next        = y0_reg;
        dy_next        = dy_reg;
        down_next      = down_reg;
        prod_next      = prod_reg;
        gain_next      = gain_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        outl_next      = outl_reg;
        outr_next      = outr_reg;
        fin_next       = fin_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        // Drop a result once it is taken
        if (out_valid_reg && result_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    if (sample_ch.item.func == FUNC_AUDIO)
                    begin
                        sl_next    = sample_ch.item.sample_left;
                        sr_next    = sample_ch.item.sample_right;
                        x0_next    = '0;
                        idx_next   = '0;
                        state_next = (seg_reg >= SEG_END) ? ST_SCAN : ST_PREP;
                    end
                    else
                    begin
                        outl_next = '0;
                        outr_next = '0;
                        gain_next = '0;
                        fin_next  = (seg_reg >= SEG_END);
                        if (sample_ch.item.func == FUNC_RELEASE)
                            armed_next = 1'b0;
                        else if (sample_ch.item.func == FUNC_RESTART)
                        begin
                            seg_next   = SEG_ATTACK;
                            pos_next   = '0;
                            armed_next = 1'b1;
                            fin_next   = 1'b0;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_PREP:
            begin
                // Sum segment lengths up to the current segment
                if (idx_reg == seg_reg[1:0])
                begin
                    x1_next    = x0_reg + POS_W'(prep_len);
                    state_next = ST_SCAN;
                end
                else
                begin
                    x0_next  = x0_reg + POS_W'(prep_len);
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_SCAN:
            begin
                if (seg_reg >= SEG_END)
                begin
                    outl_next  = sl_reg;
                    outr_next  = (CHANNELS >= 2) ? sr_reg : '0;
                    gain_next  = UNITY;
                    fin_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (armed_reg && seg_reg == SEG_RELEASE)
                begin
                    gain_next  = sus;
                    state_next = ST_MULL;
                end
                else if (pos_reg < x1_reg)
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= x1_reg)
                        seg_next = seg_reg + 3'd1;
                    y0_next   = seg_y0;
                    dy_next   = seg_dy;
                    down_next = seg_down;
                    if (pos_reg < x0_reg || x1_reg <= x0_reg)
                    begin
                        gain_next  = seg_y0;
                        state_next = ST_MULL;
                    end
                    else
                    begin
                        off_next   = FRAMES_W'(pos_reg - x0_reg);
                        len_next   = FRAMES_W'(x1_reg - x0_reg);
                        state_next = ST_MULOFF;
                    end
                end
                else
                begin
                    // Segment passed: advance to the next one
                    seg_next = seg_reg + 3'd1;
                    x0_next  = x1_reg;
                    x1_next  = x1_reg + POS_W'(next_len);
                end
            end
            ST_MULOFF:
            begin
                mul_a      = $signed({1'b0, off_reg});
                mul_b      = $signed({1'b0, dy_reg});
                prod_next  = mul_p;
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    gain_next  = down_reg ? (y0_reg - div_q) : (y0_reg + div_q);
                    state_next = ST_MULL;
                end
            end
            ST_MULL:
            begin
                mul_a      = (FRAMES_W+1)'(sl_reg);
                mul_b      = $signed({1'b0, gain_reg});
                prod_next  = mul_p;
                state_next = ST_MULR;
            end
            ST_MULR:
            begin
                outl_next  = sat_q15(prod_reg);
                mul_a      = (FRAMES_W+1)'(sr_reg);
                mul_b      = $signed({1'b0, gain_reg});
                prod_next  = mul_p;
                state_next = ST_SATR;
            end
            ST_SATR:
            begin
                outr_next  = (CHANNELS >= 2) ? sat_q15(prod_reg) : '0;
                fin_next   = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.out_left  = outl_reg;
                    out_item_next.out_right = outr_reg;
                    out_item_next.gain      = gain_reg;
                    out_item_next.finished  = fin_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Divider unit
    adsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[FRAMES_W+DIV_STEPS-1:0]),
        .divisor  (len_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Hold configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg    <= '0;
            hold_reg      <= '0;
            decay_reg     <= '0;
            sustain_reg   <= UNITY;
            release_reg   <= '0;
            state_reg     <= ST_IDLE;
            seg_reg       <= SEG_ATTACK;
            pos_reg       <= '0;
            armed_reg     <= 1'b1;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_ATTACK:  attack_reg  <= cfg_wdata;
                    REG_HOLD:    hold_reg    <= cfg_wdata;
                    REG_DECAY:   decay_reg   <= cfg_wdata;
                    REG_SUSTAIN: sustain_reg <= cfg_wdata[GAIN_W-1:0];
                    REG_RELEASE: release_reg <= cfg_wdata;
                    default:     ;
                endcase
            end
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            pos_reg       <= pos_next;
            armed_reg     <= armed_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working values and the result payload
    always_ff @(posedge clk)
    begin
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        off_reg      <= off_next;
        len_reg      <= len_next;
        y0_reg       <= y0_next;
        dy_reg       <= dy_next;
        down_reg     <= down_next;
        prod_reg     <= prod_next;
        gain_reg     <= gain_next;
        sl_reg       <= sl_next;
        sr_reg       <= sr_next;
        outl_reg     <= outl_next;
        outr_reg     <= outr_next;
        fin_reg      <= fin_next;
        out_item_reg <= out_item_next;
    end

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign result_ch.valid = out_valid_reg;
    assign result_ch.item  = out_item_reg;

    // The divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> state_reg == ST_DIV)
        else $error("divider active outside its wait state");

    // No new item while the divider still works
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.ready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    // Segment number never runs past the end
    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg <= SEG_END)
        else $error("segment index out of range");

    // A result leaving the sequencer shows up on the output
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!out_valid_reg || result_ch.ready)) |=> result_ch.valid)
        else $error("emitted result not presented");

endmodule

`default_nettype wire
